>>> hw/rtl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

>>> hw/rtl/rtbe_pkg.sv
// ----------------------------------------------------------------------------
// rtbe_pkg
// shared types and codes of the retry table
// ----------------------------------------------------------------------------
package rtbe_pkg;
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_TRY  = 2'd2;

    localparam logic [2:0] RC_ADDED   = 3'd0;
    localparam logic [2:0] RC_FULL    = 3'd1;
    localparam logic [2:0] RC_DUE     = 3'd2;
    localparam logic [2:0] RC_NONE    = 3'd3;
    localparam logic [2:0] RC_DONE    = 3'd4;
    localparam logic [2:0] RC_GAVEUP  = 3'd5;
    localparam logic [2:0] RC_BAD     = 3'd6;
    localparam logic [2:0] RC_REQUEUE = 3'd7;

    localparam logic [7:0]  DEFAULT_LIMIT = 8'd5;
    localparam logic [15:0] DEFAULT_BASE  = 16'd1000;
    localparam logic [47:0] TIME_MAX      = {48{1'b1}};
    localparam int          ENT_W         = 80;

    typedef struct packed {
        logic load;       // latch the input item
        logic add_wr;     // write new entry at count
        logic scan_rd;    // read at scan pointer
        logic scan_step;  // compare read data, advance
        logic try_rd;     // read at index
        logic try_eval;   // evaluate attempt
        logic try_wr;     // write updated entry
        logic shift_rd;   // read entry ptr+1
        logic shift_wr;   // write it to ptr
        logic finish;     // emit result
    } t_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       idx_ok;
        logic       found;
        logic       scan_end;
        logic       remove;
        logic       shift_end;
    } t_sts;
endpackage

>>> hw/rtl/rtbe_ram.sv
// ----------------------------------------------------------------------------
// rtbe_ram
// generic simple dual port ram (one write port, one read port) with registered read
// ----------------------------------------------------------------------------
module rtbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> hw/rtl/rtbe_datapath.sv
// ----------------------------------------------------------------------------
// rtbe_datapath
// entry store, scan, backoff and shift datapath
// ----------------------------------------------------------------------------
module rtbe_datapath #(
    parameter int ENTRIES = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rtbe_pkg::t_cmd        i_cmd,
    output rtbe_pkg::t_sts        o_sts,
    input  logic [1:0]            i_opcode,
    input  logic [47:0]           i_now_time,
    input  logic [7:0]            i_limit_attempts,
    input  logic [15:0]           i_base_delay,
    input  logic [4:0]            i_entry_index,
    input  logic                  i_succeeded,
    output logic                  o_result_valid,
    output logic [2:0]            o_result_code,
    output logic [4:0]            o_result_index,
    output logic [5:0]            o_entry_count,
    output logic                  o_requeued
);
    import rtbe_pkg::*;
    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [1:0]  r_op;
    logic [47:0] r_now;
    logic [7:0]  r_lim;
    logic [15:0] r_base;
    logic [4:0]  r_idx;
    logic        r_ok;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_ptr;
    logic [2:0]  r_code;
    logic [4:0]  r_rindex;
    logic        r_found, r_remove;
    logic [47:0] r_back;
    logic [7:0]  r_ac;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [ENT_W-1:0] wdata, rdata;
    logic [7:0]  rd_ac, rd_lim, inc_ac;
    logic [15:0] rd_base, add_base;
    logic [47:0] rd_due;
    logic [63:0] shifted;
    logic [48:0] sum_add, sum_try;
    logic [47:0] due_add, due_try;

    assign {rd_ac, rd_lim, rd_base, rd_due} = rdata;
    assign inc_ac   = (rd_ac == 8'hFF) ? rd_ac : rd_ac + 8'd1;
    assign add_base = (r_base == 16'd0) ? DEFAULT_BASE : r_base;
    assign sum_add  = {1'b0, r_now} + {33'd0, add_base};
    assign due_add  = sum_add[48] ? TIME_MAX : sum_add[47:0];
    assign sum_try  = {1'b0, r_now} + {1'b0, r_back};
    assign due_try  = sum_try[48] ? TIME_MAX : sum_try[47:0];
    assign shifted  = {48'd0, rd_base} << inc_ac[5:0];

    rtbe_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        we    = 1'b0;
        waddr = r_ptr;
        wdata = rdata;
        raddr = r_ptr;
        if (i_cmd.add_wr) begin
            we    = 1'b1;
            waddr = r_cnt[AW-1:0];
            wdata = {8'd0, (r_lim == 8'd0) ? DEFAULT_LIMIT : r_lim, add_base, due_add};
        end else if (i_cmd.try_wr) begin
            we    = 1'b1;
            waddr = r_idx[AW-1:0];
            wdata = {r_ac, rd_lim, rd_base, due_try};
        end else if (i_cmd.shift_wr) begin
            we    = 1'b1;
        end
        if (i_cmd.try_rd) begin
            raddr = r_idx[AW-1:0];
        end else if (i_cmd.shift_rd) begin
            raddr = r_ptr + AW'(1);
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (i_cmd.add_wr) begin
            n_cnt = r_cnt + CW'(1);
        end else if (i_cmd.finish && r_remove) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    assign o_sts.op        = r_op;
    assign o_sts.full      = (r_cnt >= CW'(ENTRIES));
    assign o_sts.idx_ok    = ({1'b0, r_idx} < 6'(r_cnt)) && (32'(r_idx) < ENTRIES);
    assign o_sts.found     = r_found;
    assign o_sts.scan_end  = ({1'b0, r_ptr} + CW'(1)) >= r_cnt;
    assign o_sts.remove    = r_remove;
    assign o_sts.shift_end = ({1'b0, r_ptr} + CW'(2)) >= r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt          <= '0;
            o_result_valid <= 1'b0;
            r_found        <= 1'b0;
            r_remove       <= 1'b0;
        end else begin
            r_cnt          <= n_cnt;
            o_result_valid <= i_cmd.finish;
            if (i_cmd.load) begin
                r_op     <= i_opcode;
                r_now    <= i_now_time;
                r_lim    <= i_limit_attempts;
                r_base   <= i_base_delay;
                r_idx    <= i_entry_index;
                r_ok     <= i_succeeded;
                r_ptr    <= '0;
                r_found  <= 1'b0;
                r_remove <= 1'b0;
                r_code   <= (i_opcode == OP_ADD && o_sts.full) ? RC_FULL : RC_BAD;
                r_rindex <= '0;
            end
            if (i_cmd.add_wr) begin
                r_code   <= RC_ADDED;
                r_rindex <= 5'(r_cnt);
            end
            if (i_cmd.scan_rd && !i_cmd.scan_step) begin
                r_code <= RC_NONE;
            end
            if (i_cmd.scan_step) begin
                if (({1'b0, r_ptr} < r_cnt) && (r_now >= rd_due)) begin
                    r_found  <= 1'b1;
                    r_code   <= RC_DUE;
                    r_rindex <= 5'(r_ptr);
                end else begin
                    r_ptr <= r_ptr + AW'(1);
                end
            end
            if (i_cmd.try_eval) begin
                r_ac <= inc_ac;
                if (inc_ac >= 8'd48 || shifted[63:48] != 16'd0) begin
                    r_back <= TIME_MAX;
                end else begin
                    r_back <= shifted[47:0];
                end
                r_ptr <= r_idx[AW-1:0];
                if (r_ok) begin
                    r_remove <= 1'b1;
                    r_code   <= RC_DONE;
                end else if (inc_ac >= rd_lim) begin
                    r_remove <= 1'b1;
                    r_code   <= RC_GAVEUP;
                end else begin
                    r_code <= RC_REQUEUE;
                end
            end
            if (i_cmd.shift_wr) begin
                r_ptr <= r_ptr + AW'(1);
            end
            if (i_cmd.finish) begin
                o_result_code  <= r_code;
                o_result_index <= r_rindex;
                o_entry_count  <= 6'(n_cnt);
                o_requeued     <= (r_code == RC_REQUEUE);
            end
        end
    end
endmodule

>>> hw/rtl/rtbe_ctrl.sv
// ----------------------------------------------------------------------------
// rtbe_ctrl
// operation sequencer of the retry table
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module rtbe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  rtbe_pkg::t_sts i_sts,
    output rtbe_pkg::t_cmd o_cmd
);
    import rtbe_pkg::*;
    localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2, S_CMP = 4'd3,
        S_TRD = 4'd4, S_TEV = 4'd5, S_TWR = 4'd6, S_SRD = 4'd7, S_SWR = 4'd8,
        S_FIN = 4'd9;
    logic [3:0] r_state, n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                case (i_sts.op)
                    OP_ADD: begin
                        o_cmd.add_wr = !i_sts.full;
                        n_state      = S_FIN;
                    end
                    OP_FIND: begin
                        o_cmd.scan_rd = 1'b1;
                        n_state       = S_SCAN;
                    end
                    OP_TRY: begin
                        o_cmd.try_rd = 1'b1;
                        n_state      = i_sts.idx_ok ? S_TEV : S_FIN;
                    end
                    default: n_state = S_FIN;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_CMP;
            end
            S_CMP: begin
                o_cmd.scan_rd   = 1'b1;
                o_cmd.scan_step = 1'b1;
                n_state         = (!i_sts.found && !i_sts.scan_end) ? S_SCAN : S_FIN;
            end
            S_TEV: begin
                o_cmd.try_eval = 1'b1;
                o_cmd.try_rd   = 1'b1;
                n_state        = S_TWR;
            end
            S_TWR: begin
                if (i_sts.remove) begin
                    n_state = i_sts.scan_end ? S_FIN : S_SRD;
                end else begin
                    o_cmd.try_rd = 1'b1;
                    o_cmd.try_wr = 1'b1;
                    n_state      = S_FIN;
                end
            end
            S_SRD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_SWR;
            end
            S_SWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = i_sts.shift_end ? S_FIN : S_SRD;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `ASSERT_NEXT(a_fin_idle, i_clk, i_rst_n, o_cmd.finish, r_state == S_IDLE)
    `ASSERT_IMPLIES(a_one_wr, i_clk, i_rst_n, o_cmd.add_wr, !o_cmd.try_wr && !o_cmd.shift_wr)
    `ASSERT_NEXT(a_load_busy, i_clk, i_rst_n, o_cmd.load, o_busy)
endmodule

>>> hw/rtl/retry_table_with_exponential_backoff_unit.sv
// ----------------------------------------------------------------------------
// retry_table_with_exponential_backoff_unit
// retry table with exponential backoff, controller plus datapath
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy low. The result shows for one
// cycle under o_result_valid and cannot be stalled. An add, an unknown opcode
// or a bad index go from decode straight to finish; a find-due reads and
// compares one entry per scan step until a due entry or the last one (one pass
// even on an empty table); an attempt reads and evaluates the entry, then
// writes it back or shifts the later entries down on removal. The entry memory
// has a registered read.
module retry_table_with_exponential_backoff_unit #(
    parameter int ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [47:0] i_now_time,
    input  logic [7:0]  i_limit_attempts,
    input  logic [15:0] i_base_delay,
    input  logic [4:0]  i_entry_index,
    input  logic        i_succeeded,
    output logic        o_result_valid,
    output logic [2:0]  o_result_code,
    output logic [4:0]  o_result_index,
    output logic [5:0]  o_entry_count,
    output logic        o_requeued
);
    import rtbe_pkg::*;
    t_cmd cmd;
    t_sts sts;
    logic start_ok;
    assign start_ok = start && !busy;

    rtbe_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start_ok), .o_busy(busy),
        .i_sts(sts), .o_cmd(cmd)
    );

    rtbe_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_opcode(i_opcode), .i_now_time(i_now_time),
        .i_limit_attempts(i_limit_attempts), .i_base_delay(i_base_delay),
        .i_entry_index(i_entry_index), .i_succeeded(i_succeeded),
        .o_result_valid(o_result_valid), .o_result_code(o_result_code),
        .o_result_index(o_result_index), .o_entry_count(o_entry_count),
        .o_requeued(o_requeued)
    );
endmodule
